/* src/plc_pkg.sv */
`timescale 1ns / 1ps

package plc_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_ENTRY_WIDTH = 32;

    localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RETRIEVE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SWAP     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  second_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [POS_W-1:0]    found_position;
        logic                both_found;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef enum logic [1:0] {
        WS_RD = 2'd0,
        WS_A  = 2'd1,
        WS_B  = 2'd2
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } t_cnt_op;

    typedef struct packed {
        logic                load_item;
        logic                rd_en;
        logic                scan_rd;
        logic                scan_clr;
        logic                keep;
        logic                wr_en;
        t_wr_sel             wr_sel;
        t_cnt_op             cnt_op;
        logic                load_out;
        logic                out_rd;
        logic                out_found;
        logic                out_both;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                ins_ok;
        logic                rd_ok;
        logic                full;
        logic                empty;
        logic                ins_tail;
        logic                rm_tail;
        logic                val_eq;
        logic                hit_a;
        logic                hit_b;
    } t_dp_sts;

endpackage

/* src/positional_list_engine.sv */
`timescale 1ns / 1ps

// Positional ordered list engine.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one command item:
// insert, remove, retrieve, search, swap or clear. Every command yields exactly
// one result item on the output channel (o_out_valid / i_out_ready / o_out_item).
// Entries live in a single-port-read, single-port-write store, so shifts and scans
// move one entry per cycle. Insert and remove shift the entries from the given
// position to the tail (none when it is the tail); search and swap scan every
// entry, and a swap writes both values only when both are found. Retrieve, clear,
// error cases and a swap with equal values or an empty list neither shift nor scan.
// One item is processed at a time; a new item is taken as soon as the engine is
// idle, even while the previous result still sits in the output register.
// When the receiver stalls, a finished result waits until the output register is
// free, and the engine takes no new item while it waits.
// Reset empties the list (count zero) and drops any pending result. The store
// itself is not cleared; only entries below the count are ever read.

module positional_list_engine #(
    parameter int CAPACITY    = plc_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = plc_pkg::DEF_ENTRY_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output plc_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(CAPACITY);

    plc_pkg::t_dp_cmd w_cmd;
    plc_pkg::t_dp_sts w_sts;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_pos_idx;
    logic [AW-1:0]    w_last_idx;
    logic [AW-1:0]    w_idx_a;
    logic [AW-1:0]    w_idx_b;

    plc_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .i_pos_idx   (w_pos_idx),
        .i_last_idx  (w_last_idx),
        .i_idx_a     (w_idx_a),
        .i_idx_b     (w_idx_b),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr)
    );

    plc_datapath #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .o_sts      (w_sts),
        .o_pos_idx  (w_pos_idx),
        .o_last_idx (w_last_idx),
        .o_idx_a    (w_idx_a),
        .o_idx_b    (w_idx_b),
        .o_out_item (o_out_item)
    );

endmodule

/* src/plc_datapath.sv */
`timescale 1ns / 1ps

module plc_datapath #(
    parameter int CAPACITY    = plc_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = plc_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  plc_pkg::t_in_item            i_in_item,
    input  plc_pkg::t_dp_cmd             i_cmd,
    input  logic [$clog2(CAPACITY)-1:0]  i_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]  i_wr_addr,
    output plc_pkg::t_dp_sts             o_sts,
    output logic [$clog2(CAPACITY)-1:0]  o_pos_idx,
    output logic [$clog2(CAPACITY)-1:0]  o_last_idx,
    output logic [$clog2(CAPACITY)-1:0]  o_idx_a,
    output logic [$clog2(CAPACITY)-1:0]  o_idx_b,
    output plc_pkg::t_out_item           o_out_item
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > plc_pkg::POS_W) ? CNT_W : plc_pkg::POS_W) + 1;

    logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
    logic [ENTRY_WIDTH-1:0] r_rd_data;
    logic [ENTRY_WIDTH-1:0] r_keep;
    plc_pkg::t_in_item      r_item;
    plc_pkg::t_out_item     r_out;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   r_chk;
    logic                   r_hit_a;
    logic                   r_hit_b;
    logic                   r_first_hit;
    logic [AW-1:0]          r_chk_idx;
    logic [AW-1:0]          r_idx_a;
    logic [AW-1:0]          r_idx_b;
    logic [AW-1:0]          r_first_idx;
    logic [ENTRY_WIDTH-1:0] w_va;
    logic [ENTRY_WIDTH-1:0] w_vb;
    logic [ENTRY_WIDTH-1:0] w_wr_data;
    logic [CMP_W-1:0]       w_pos;
    logic [CMP_W-1:0]       w_cnt;

    assign w_va  = ENTRY_WIDTH'(r_item.value);
    assign w_vb  = ENTRY_WIDTH'(r_item.second_value);
    assign w_pos = CMP_W'(r_item.position);
    assign w_cnt = CMP_W'(r_cnt);

    always_comb begin
        o_sts.action   = r_item.action;
        o_sts.ins_ok   = (w_pos != '0) && (w_pos <= w_cnt + 1'b1);
        o_sts.rd_ok    = (w_pos != '0) && (w_pos <= w_cnt);
        o_sts.full     = (w_cnt == CMP_W'(CAPACITY));
        o_sts.empty    = (r_cnt == '0);
        o_sts.ins_tail = (w_pos == w_cnt + 1'b1);
        o_sts.rm_tail  = (w_pos == w_cnt);
        o_sts.val_eq   = (w_va == w_vb);
        o_sts.hit_a    = r_hit_a;
        o_sts.hit_b    = r_hit_b;
    end

    assign o_pos_idx  = AW'(w_pos - 1'b1);
    assign o_last_idx = AW'(w_cnt - 1'b1);
    assign o_idx_a    = r_idx_a;
    assign o_idx_b    = r_idx_b;
    assign o_out_item = r_out;

    always_comb begin
        case (i_cmd.wr_sel)
            plc_pkg::WS_A: w_wr_data = w_va;
            plc_pkg::WS_B: w_wr_data = w_vb;
            default:       w_wr_data = r_rd_data;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            plc_pkg::CNT_INC: n_cnt = r_cnt + 1'b1;
            plc_pkg::CNT_DEC: n_cnt = r_cnt - 1'b1;
            plc_pkg::CNT_CLR: n_cnt = '0;
            default:          n_cnt = r_cnt;
        endcase
    end

    // Entry store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.keep) begin
            r_keep <= r_rd_data;
        end
        r_chk_idx <= i_rd_addr;
        if (i_cmd.load_out) begin
            r_out.read_value     <= i_cmd.out_rd ? plc_pkg::VALUE_W'(r_keep) : '0;
            r_out.found_position <= (i_cmd.out_found && r_first_hit)
                                    ? plc_pkg::POS_W'(r_first_idx) + 1'b1 : '0;
            r_out.both_found     <= i_cmd.out_both;
            r_out.entry_count    <= plc_pkg::COUNT_W'(r_cnt);
            r_out.status         <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Scan trackers: the swap keeps the last match of each value, the search the first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk       <= 1'b0;
            r_hit_a     <= 1'b0;
            r_hit_b     <= 1'b0;
            r_first_hit <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_rd;
            if (i_cmd.scan_clr) begin
                r_hit_a     <= 1'b0;
                r_hit_b     <= 1'b0;
                r_first_hit <= 1'b0;
            end else if (r_chk) begin
                if (r_rd_data == w_va) begin
                    r_hit_a <= 1'b1;
                    r_idx_a <= r_chk_idx;
                    if (!r_first_hit) begin
                        r_first_hit <= 1'b1;
                        r_first_idx <= r_chk_idx;
                    end
                end else if (r_rd_data == w_vb) begin
                    r_hit_b <= 1'b1;
                    r_idx_b <= r_chk_idx;
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_cnt != $past(r_cnt))) |->
            ((r_cnt == $past(r_cnt) + 1'b1) || (r_cnt == $past(r_cnt) - 1'b1)
             || (r_cnt == '0)))
        else $error("entry count changed by more than one");

endmodule

/* src/plc_ctrl.sv */
`timescale 1ns / 1ps

module plc_ctrl #(
    parameter int CAPACITY = plc_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    input  plc_pkg::t_dp_sts             i_sts,
    input  logic [$clog2(CAPACITY)-1:0]  i_pos_idx,
    input  logic [$clog2(CAPACITY)-1:0]  i_last_idx,
    input  logic [$clog2(CAPACITY)-1:0]  i_idx_a,
    input  logic [$clog2(CAPACITY)-1:0]  i_idx_b,
    output plc_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(CAPACITY)-1:0]  o_rd_addr,
    output logic [$clog2(CAPACITY)-1:0]  o_wr_addr
);

    localparam int AW = $clog2(CAPACITY);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DECODE   = 14'b00000000000010,
        S_UP       = 14'b00000000000100,
        S_UP_LAST  = 14'b00000000001000,
        S_PUT      = 14'b00000000010000,
        S_GET      = 14'b00000000100000,
        S_DN       = 14'b00000001000000,
        S_DN_LAST  = 14'b00000010000000,
        S_SCAN     = 14'b00000100000000,
        S_SCAN_END = 14'b00001000000000,
        S_SWAP_DEC = 14'b00010000000000,
        S_SWA      = 14'b00100000000000,
        S_SWB      = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } t_state;

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_ptr, n_ptr;
    logic [AW-1:0]                 r_wptr, n_wptr;
    logic                          r_pend, n_pend;
    logic                          r_out_vld, n_out_vld;
    logic [plc_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                          r_out_rd, n_out_rd;
    logic                          r_out_found, n_out_found;
    logic                          r_out_both, n_out_both;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_pend      = r_pend;
        n_status    = r_status;
        n_out_rd    = r_out_rd;
        n_out_found = r_out_found;
        n_out_both  = r_out_both;
        o_rd_addr   = r_ptr;
        o_wr_addr   = r_wptr;

        o_cmd           = '0;
        o_cmd.wr_sel    = plc_pkg::WS_RD;
        o_cmd.cnt_op    = plc_pkg::CNT_HOLD;
        o_cmd.out_rd    = r_out_rd;
        o_cmd.out_found = r_out_found;
        o_cmd.out_both  = r_out_both;
        o_cmd.status    = r_status;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status    = plc_pkg::ST_OK;
                n_out_rd    = 1'b0;
                n_out_found = 1'b0;
                n_out_both  = 1'b0;
                n_pend      = 1'b0;
                n_state     = S_DONE;
                case (i_sts.action)
                    plc_pkg::ACT_INSERT: begin
                        if (!i_sts.ins_ok) begin
                            n_status = plc_pkg::ST_BADPOS;
                        end else if (i_sts.full) begin
                            n_status = plc_pkg::ST_FULL;
                        end else if (i_sts.ins_tail) begin
                            n_state = S_PUT;
                        end else begin
                            n_ptr   = i_last_idx;
                            n_state = S_UP;
                        end
                    end
                    plc_pkg::ACT_REMOVE, plc_pkg::ACT_RETRIEVE: begin
                        if (!i_sts.rd_ok) begin
                            n_status = plc_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_rd_addr   = i_pos_idx;
                            n_out_rd    = 1'b1;
                            n_state     = S_GET;
                        end
                    end
                    plc_pkg::ACT_SEARCH: begin
                        o_cmd.scan_clr = 1'b1;
                        n_out_found    = 1'b1;
                        n_ptr          = '0;
                        if (!i_sts.empty) begin
                            n_state = S_SCAN;
                        end
                    end
                    plc_pkg::ACT_SWAP: begin
                        o_cmd.scan_clr = 1'b1;
                        n_ptr          = '0;
                        if (!i_sts.empty && !i_sts.val_eq) begin
                            n_state = S_SCAN;
                        end
                    end
                    plc_pkg::ACT_CLEAR: begin
                        o_cmd.cnt_op = plc_pkg::CNT_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            // Shift toward the tail, highest entry first; each write lands two
            // addresses above the read issued in the same cycle.
            S_UP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.wr_en  = r_pend;
                n_wptr       = r_ptr + 1'b1;
                n_pend       = 1'b1;
                if (r_ptr == i_pos_idx) begin
                    n_state = S_UP_LAST;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            S_UP_LAST: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_PUT;
            end
            S_PUT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = plc_pkg::WS_A;
                o_wr_addr    = i_pos_idx;
                o_cmd.cnt_op = plc_pkg::CNT_INC;
                n_state      = S_DONE;
            end
            S_GET: begin
                o_cmd.keep = 1'b1;
                if (i_sts.action == plc_pkg::ACT_RETRIEVE) begin
                    n_state = S_DONE;
                end else if (i_sts.rm_tail) begin
                    o_cmd.cnt_op = plc_pkg::CNT_DEC;
                    n_state      = S_DONE;
                end else begin
                    n_ptr   = i_pos_idx + 1'b1;
                    n_state = S_DN;
                end
            end
            S_DN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.wr_en = r_pend;
                n_wptr      = r_ptr - 1'b1;
                n_pend      = 1'b1;
                if (r_ptr == i_last_idx) begin
                    n_state = S_DN_LAST;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DN_LAST: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.cnt_op = plc_pkg::CNT_DEC;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.scan_rd = 1'b1;
                if (r_ptr == i_last_idx) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SCAN_END: begin
                n_state = (i_sts.action == plc_pkg::ACT_SWAP) ? S_SWAP_DEC : S_DONE;
            end
            S_SWAP_DEC: begin
                n_state = (i_sts.hit_a && i_sts.hit_b) ? S_SWA : S_DONE;
            end
            S_SWA: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = plc_pkg::WS_B;
                o_wr_addr    = i_idx_a;
                n_state      = S_SWB;
            end
            S_SWB: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = plc_pkg::WS_A;
                o_wr_addr    = i_idx_b;
                n_out_both   = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_vld = o_cmd.load_out || (r_out_vld && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_wptr      <= n_wptr;
        r_status    <= n_status;
        r_out_rd    <= n_out_rd;
        r_out_found <= n_out_found;
        r_out_both  <= n_out_both;
    end

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_en && o_cmd.rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("store read and written at the same address");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over an item not yet taken");

    a_vld_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_vld)) |-> $past(o_cmd.load_out))
        else $error("output valid raised without a result");

endmodule
